@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the core RTL.
// Each macro expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/mrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrp_pkg
// Types, codes and constants shared by the minutiae record parser files.
// ----------------------------------------------------------------------------
package mrp_pkg;

	// Record header constants.
	localparam logic [31:0] FORMAT_MAGIC    = 32'h464D_5200;
	localparam logic [31:0] VERSION_MAGIC   = 32'h2032_3000;
	localparam logic [31:0] MIN_RECORD_LEN  = 32'd24;
	localparam logic [7:0]  MAX_QUALITY     = 8'd100;
	localparam logic [7:0]  NUM_POSITIONS   = 8'd11;
	localparam logic [3:0]  NUM_IMPRESSIONS = 4'd9;
	localparam logic [1:0]  NUM_MIN_TYPES   = 2'd3;
	localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

	// Parse phase: the field being received. Its value is the field code.
	typedef enum logic [4:0] {
		PH_FORMAT      = 5'd0,
		PH_VERSION     = 5'd1,
		PH_LENGTH      = 5'd2,
		PH_CERT_DEV    = 5'd3,
		PH_SIZE_X      = 5'd4,
		PH_SIZE_Y      = 5'd5,
		PH_RES_X       = 5'd6,
		PH_RES_Y       = 5'd7,
		PH_NUM_VIEWS   = 5'd8,
		PH_RESERVED    = 5'd9,
		PH_FINGER_POS  = 5'd10,
		PH_IMPRESSION  = 5'd11,
		PH_FINGER_QUAL = 5'd12,
		PH_NUM_MIN     = 5'd13,
		PH_MIN_TYPE_X  = 5'd14,
		PH_MIN_Y       = 5'd15,
		PH_MIN_ANGLE   = 5'd16,
		PH_MIN_QUAL    = 5'd17,
		PH_EXT_LEN     = 5'd18,
		PH_EXT_BYTE    = 5'd19
	} phase_t;

	typedef enum logic [3:0] {
		ERR_NONE        = 4'd0,
		ERR_EARLY_END   = 4'd1,
		ERR_FORMAT      = 4'd2,
		ERR_VERSION     = 4'd3,
		ERR_LENGTH      = 4'd4,
		ERR_RESERVED    = 4'd5,
		ERR_POSITION    = 4'd6,
		ERR_IMPRESSION  = 4'd7,
		ERR_FINGER_QUAL = 4'd8,
		ERR_MIN_TYPE    = 4'd9,
		ERR_MIN_QUAL    = 4'd10
	} err_t;

	// One byte of the record stream.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	// One completed field.
	typedef struct packed {
		logic [4:0]  field_code;
		logic [31:0] value;
		logic [11:0] value_low;
		logic [7:0]  view_index;
		logic [7:0]  minutia_index;
		logic [3:0]  error_code;
		logic        record_done;
		logic [31:0] byte_count;
	} result_t;

	// Index of the last byte of the field received in a phase.
	function automatic logic [1:0] last_byte_idx(input phase_t ph);
		logic [1:0] idx;
		case (ph)
			PH_FORMAT, PH_VERSION, PH_LENGTH: idx = 2'd3;
			PH_CERT_DEV, PH_SIZE_X, PH_SIZE_Y, PH_RES_X, PH_RES_Y,
			PH_MIN_TYPE_X, PH_MIN_Y, PH_EXT_LEN: idx = 2'd1;
			default: idx = 2'd0;
		endcase
		return idx;
	endfunction

endpackage

@@ rtl/core/mrp_if.sv @@
// ----------------------------------------------------------------------------
// mrp_if
// Valid/ready channels of the minutiae record parser: record bytes in,
// completed fields out.
// ----------------------------------------------------------------------------
interface mrp_in_if;
	import mrp_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface mrp_out_if;
	import mrp_pkg::*;

	logic    valid;
	logic    ready;
	result_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

@@ rtl/core/minutiae_record_parser_core.sv @@
// ----------------------------------------------------------------------------
// minutiae_record_parser_core
// Byte-serial parser of a finger minutiae record with field-level output.
// ----------------------------------------------------------------------------
// Usage:
// rec_bytes carries one record byte per item, most significant byte first
// for multi-byte fields; end_of_data set in an item means the source ran out.
// fields carries one item for each completed field, with split subfields,
// view and minutia indices, an error code and the running byte count.
// A byte that does not complete a field gives no item on fields.
// Throughput is one byte per cycle while fields does not stall: the field
// state machine does a shift, a few compares and counter updates between the
// input register and the output register, where the field item of the
// completing byte is written when the input register advances.
// An item with record_done set ends a record (normal end or error); the
// parser is then back at the format id of a fresh record.
// Reset returns the parser to the start of a record and empties both
// registers. When fields stalls, a held byte that would produce another field
// waits in the input register and rec_bytes drops ready; other bytes move on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module minutiae_record_parser_core (
	input  logic             clk,
	input  logic             arst_n,
	mrp_in_if.sink           rec_bytes,
	mrp_out_if.source        fields
);
	import mrp_pkg::*;

	// Input register.
	logic     valid_s1;
	in_item_t item_s1;

	// Parser state.
	phase_t      phase_q, phase_nxt;
	logic [1:0]  bif_q, bif_nxt;
	logic [31:0] acc_q, acc_nxt;
	logic [31:0] rec_len_q, rec_len_nxt;
	logic [31:0] bytes_q, bytes_nxt;
	logic [7:0]  view_total_q, view_total_nxt;
	logic [7:0]  view_cnt_q, view_cnt_nxt;
	logic [7:0]  min_total_q, min_total_nxt;
	logic [7:0]  min_cnt_q, min_cnt_nxt;
	logic [15:0] ext_rem_q, ext_rem_nxt;

	// Output register.
	logic    out_valid_q;
	result_t out_q;

	// Step logic.
	logic        has_result;
	logic        restart;
	result_t     res;
	logic [31:0] bytes_inc;
	logic [31:0] acc_shift;
	logic [31:0] rec_len_eff;
	logic [7:0]  view_cnt_inc;
	logic [7:0]  min_cnt_inc;
	logic [15:0] ext_rem_dec;
	logic        view_end;
	logic        done;
	err_t        err;

	logic out_free;
	logic s1_adv;

	// Handshake: the input register moves on when its byte gives no field
	// or the output register is free to take one.
	assign out_free        = !out_valid_q || fields.ready;
	assign s1_adv          = valid_s1 && (!has_result || out_free);
	assign rec_bytes.ready = !valid_s1 || s1_adv;
	assign fields.valid    = out_valid_q;
	assign fields.item     = out_q;

	assign bytes_inc    = (bytes_q == COUNT_MAX) ? bytes_q : bytes_q + 32'd1;
	assign acc_shift    = {acc_q[23:0], item_s1.data_byte};
	assign rec_len_eff  = (phase_q == PH_LENGTH) ? acc_shift : rec_len_q;
	assign view_cnt_inc = view_cnt_q + 8'd1;
	assign min_cnt_inc  = min_cnt_q + 8'd1;
	assign ext_rem_dec  = ext_rem_q - 16'd1;

	// Next state of the field walk.
	always_comb begin
		phase_nxt      = phase_q;
		bif_nxt        = bif_q;
		acc_nxt        = acc_q;
		rec_len_nxt    = rec_len_q;
		bytes_nxt      = bytes_q;
		view_total_nxt = view_total_q;
		view_cnt_nxt   = view_cnt_q;
		min_total_nxt  = min_total_q;
		min_cnt_nxt    = min_cnt_q;
		ext_rem_nxt    = ext_rem_q;
		view_end       = 1'b0;
		done           = 1'b0;
		restart        = 1'b0;

		if (item_s1.end_of_data) begin
			restart = 1'b1;
		end else begin
			bytes_nxt = bytes_inc;
			if (bif_q < last_byte_idx(phase_q)) begin
				bif_nxt = bif_q + 2'd1;
				acc_nxt = acc_shift;
			end else begin
				bif_nxt     = 2'd0;
				acc_nxt     = 32'd0;
				rec_len_nxt = rec_len_eff;
				if (err != ERR_NONE) begin
					restart = 1'b1;
				end else begin
					unique case (phase_q)
						PH_NUM_VIEWS: begin
							view_total_nxt = acc_shift[7:0];
							phase_nxt      = PH_RESERVED;
						end
						PH_RESERVED: begin
							view_cnt_nxt = 8'd0;
							if (view_total_q == 8'd0) done = 1'b1;
							else phase_nxt = PH_FINGER_POS;
						end
						PH_NUM_MIN: begin
							min_total_nxt = acc_shift[7:0];
							min_cnt_nxt   = 8'd0;
							phase_nxt     = (acc_shift[7:0] == 8'd0) ? PH_EXT_LEN
								: PH_MIN_TYPE_X;
						end
						PH_MIN_QUAL: begin
							min_cnt_nxt = min_cnt_inc;
							phase_nxt   = (min_cnt_inc == min_total_q) ? PH_EXT_LEN
								: PH_MIN_TYPE_X;
						end
						PH_EXT_LEN: begin
							ext_rem_nxt = acc_shift[15:0];
							if (acc_shift[15:0] == 16'd0) view_end = 1'b1;
							else phase_nxt = PH_EXT_BYTE;
						end
						PH_EXT_BYTE: begin
							ext_rem_nxt = ext_rem_dec;
							if (ext_rem_dec == 16'd0) view_end = 1'b1;
						end
						default: begin
							phase_nxt = phase_t'(5'(phase_q + 5'd1));
						end
					endcase
					// End of a view: next view or end of record.
					if (view_end) begin
						view_cnt_nxt = view_cnt_inc;
						if (view_cnt_inc == view_total_q) done = 1'b1;
						else phase_nxt = PH_FINGER_POS;
					end
					if (done) restart = 1'b1;
				end
			end
		end

		if (restart) begin
			phase_nxt      = PH_FORMAT;
			bif_nxt        = 2'd0;
			acc_nxt        = 32'd0;
			rec_len_nxt    = 32'd0;
			bytes_nxt      = 32'd0;
			view_total_nxt = 8'd0;
			view_cnt_nxt   = 8'd0;
			min_total_nxt  = 8'd0;
			min_cnt_nxt    = 8'd0;
			ext_rem_nxt    = 16'd0;
		end
	end

	// Field checks and the result item of the byte in the input register.
	always_comb begin
		res            = '0;
		res.field_code = phase_q;
		res.view_index = (phase_q >= PH_FINGER_POS) ? view_cnt_q : 8'd0;
		res.minutia_index = (phase_q >= PH_MIN_TYPE_X && phase_q <= PH_MIN_QUAL)
			? min_cnt_q : 8'd0;
		err        = ERR_NONE;
		has_result = 1'b0;

		if (item_s1.end_of_data) begin
			has_result      = 1'b1;
			res.error_code  = ERR_EARLY_END;
			res.record_done = 1'b1;
			res.byte_count  = bytes_q;
		end else if (bif_q >= last_byte_idx(phase_q)) begin
			has_result     = 1'b1;
			res.byte_count = bytes_inc;
			res.value      = acc_shift;
			case (phase_q)
				PH_CERT_DEV: begin
					res.value     = {28'd0, acc_shift[15:12]};
					res.value_low = acc_shift[11:0];
				end
				PH_IMPRESSION: begin
					res.value     = {28'd0, acc_shift[7:4]};
					res.value_low = {8'd0, acc_shift[3:0]};
				end
				PH_MIN_TYPE_X: begin
					res.value     = {18'd0, acc_shift[13:0]};
					res.value_low = {10'd0, acc_shift[15:14]};
				end
				PH_MIN_Y: begin
					res.value = {18'd0, acc_shift[13:0]};
				end
				default: ;
			endcase

			// Overrun of the total length takes precedence over field checks.
			if (rec_len_eff != 32'd0 && bytes_inc > rec_len_eff) begin
				err = ERR_LENGTH;
			end else begin
				case (phase_q)
					PH_FORMAT:
						if (acc_shift != FORMAT_MAGIC) err = ERR_FORMAT;
					PH_VERSION:
						if (acc_shift != VERSION_MAGIC) err = ERR_VERSION;
					PH_LENGTH:
						if (acc_shift < MIN_RECORD_LEN) err = ERR_LENGTH;
					PH_RESERVED:
						if (acc_shift[7:0] != 8'd0) err = ERR_RESERVED;
					PH_FINGER_POS:
						if (acc_shift[7:0] >= NUM_POSITIONS) err = ERR_POSITION;
					PH_IMPRESSION:
						if (acc_shift[3:0] >= NUM_IMPRESSIONS) err = ERR_IMPRESSION;
					PH_FINGER_QUAL:
						if (acc_shift[7:0] > MAX_QUALITY) err = ERR_FINGER_QUAL;
					PH_MIN_TYPE_X:
						if (acc_shift[15:14] >= NUM_MIN_TYPES) err = ERR_MIN_TYPE;
					PH_MIN_QUAL:
						if (acc_shift[7:0] > MAX_QUALITY) err = ERR_MIN_QUAL;
					default: ;
				endcase
			end

			if (err != ERR_NONE) begin
				res.error_code  = err;
				res.record_done = 1'b1;
			end else if (done) begin
				// Underrun of the total length at the record end.
				if (bytes_inc < rec_len_eff) res.error_code = ERR_LENGTH;
				res.record_done = 1'b1;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rec_bytes.valid && rec_bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_bytes.valid && rec_bytes.ready) begin
			item_s1 <= rec_bytes.item;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FORMAT;
			bif_q        <= 2'd0;
			acc_q        <= 32'd0;
			rec_len_q    <= 32'd0;
			bytes_q      <= 32'd0;
			view_total_q <= 8'd0;
			view_cnt_q   <= 8'd0;
			min_total_q  <= 8'd0;
			min_cnt_q    <= 8'd0;
			ext_rem_q    <= 16'd0;
		end else if (s1_adv) begin
			phase_q      <= phase_nxt;
			bif_q        <= bif_nxt;
			acc_q        <= acc_nxt;
			rec_len_q    <= rec_len_nxt;
			bytes_q      <= bytes_nxt;
			view_total_q <= view_total_nxt;
			view_cnt_q   <= view_cnt_nxt;
			min_total_q  <= min_total_nxt;
			min_cnt_q    <= min_cnt_nxt;
			ext_rem_q    <= ext_rem_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && has_result) begin
			out_valid_q <= 1'b1;
		end else if (fields.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_result) begin
			out_q <= res;
		end
	end

	// Checks on the parser's own behavior.
	`ASSERT_SAME(a_err_ends_record, out_valid_q && out_q.error_code != ERR_NONE,
		out_q.record_done)
	`ASSERT_SAME(a_header_no_index, out_valid_q && out_q.field_code < PH_FINGER_POS,
		out_q.view_index == 8'd0 && out_q.minutia_index == 8'd0)
	`ASSERT_NEXT(a_restart_clears, s1_adv && has_result && res.record_done,
		phase_q == PH_FORMAT && bytes_q == 32'd0 && bif_q == 2'd0)

endmodule
